// ===== rtl/core/hfpe_pkg.sv =====
// Shared constants and types for the hash-framed packet extractor.
package hfpe_pkg;

    localparam int unsigned DEF_BUF_DEPTH = 4096;
    localparam int unsigned MAXLEN_W      = 13;
    localparam logic [MAXLEN_W-1:0] MAXLEN_RST = 13'd4096;

    localparam logic [7:0] HEAD_MARK = 8'h23;
    localparam logic [7:0] TAIL_MARK = 8'h24;
    localparam int unsigned HDR_LEN  = 11;
    localparam int unsigned MIN_LEN  = HDR_LEN + 2;

    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_STATUS = 2'd2,
        MODE_SPARE  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK,
        ST_B0,
        ST_B1,
        ST_L0,
        ST_L1,
        ST_T0,
        ST_T1
    } t_state;

    typedef struct packed {
        logic strobe;
        logic accepted;
        logic frame_valid;
        logic last;
    } t_res_flags;

endpackage

// ===== rtl/core/hash_framed_packet_extractor.sv =====
// Top level of the hash-framed packet extractor.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------
//  command   | start, busy               | i_mode, i_data_byte
//  result    | o_strobe (one cycle)      | o_accepted .. o_delivered_frames
//  config    | i_cfg_we                  | i_cfg_wdata (max_frame_len)
//
// Push, status, spare and a pop of a pending frame are taken in idle; the result strobe
// follows in the next cycle. A pop with no frame pending runs the head search
// over the store, reading each scanned position byte by byte through the single
// registered read port, and its result strobe follows when the search ends.
// Reset is synchronous and active low; the store itself is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module hash_framed_packet_extractor #(
    parameter int unsigned BUF_DEPTH = hfpe_pkg::DEF_BUF_DEPTH,
    parameter int unsigned AW        = $clog2(BUF_DEPTH),
    parameter int unsigned CW        = $clog2(BUF_DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_mode,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_cfg_we,
    input  logic [hfpe_pkg::MAXLEN_W-1:0] i_cfg_wdata,
    output logic                          o_strobe,
    output logic                          o_accepted,
    output logic                          o_frame_valid,
    output logic [7:0]                    o_out_byte,
    output logic                          o_last,
    output logic [CW-1:0]                 o_frame_length,
    output logic [CW-1:0]                 o_buffered_bytes,
    output logic [31:0]                   o_received_frames,
    output logic [31:0]                   o_delivered_frames
);
    import hfpe_pkg::*;

    logic [MAXLEN_W-1:0] r_max_len;
    logic                we;
    logic [AW-1:0]       waddr, raddr;
    logic [7:0]          wdata, rdata;
    t_res_flags          flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAXLEN_RST;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    hfpe_store #(.BUF_DEPTH(BUF_DEPTH), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    hfpe_ctrl #(.BUF_DEPTH(BUF_DEPTH), .AW(AW), .CW(CW)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_data_byte (i_data_byte),
        .i_max_len   (r_max_len),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_flags     (flags),
        .o_flen      (o_frame_length),
        .o_fill      (o_buffered_bytes),
        .o_found     (o_received_frames),
        .o_sent      (o_delivered_frames)
    );

    assign o_strobe      = flags.strobe;
    assign o_accepted    = flags.accepted;
    assign o_frame_valid = flags.frame_valid;
    assign o_last        = flags.last;
    // The read register holds the frame byte only on a pop that found one.
    assign o_out_byte    = flags.frame_valid ? rdata : 8'h00;

endmodule

// ===== rtl/core/hfpe_store.sv =====
// Byte store: one write port and one registered read port.
module hfpe_store #(
    parameter int unsigned BUF_DEPTH = hfpe_pkg::DEF_BUF_DEPTH,
    parameter int unsigned AW        = $clog2(BUF_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    import hfpe_pkg::*;

    logic [7:0] r_mem [BUF_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/hfpe_ctrl.sv =====
// Sequencer: push, pop delivery and the head search over the circular store.
module hfpe_ctrl #(
    parameter int unsigned BUF_DEPTH = hfpe_pkg::DEF_BUF_DEPTH,
    parameter int unsigned AW        = $clog2(BUF_DEPTH),
    parameter int unsigned CW        = $clog2(BUF_DEPTH + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_mode,
    input  logic [7:0]                      i_data_byte,
    input  logic [hfpe_pkg::MAXLEN_W-1:0]   i_max_len,
    output logic                            o_we,
    output logic [AW-1:0]                   o_waddr,
    output logic [7:0]                      o_wdata,
    output logic [AW-1:0]                   o_raddr,
    input  logic [7:0]                      i_rdata,
    output hfpe_pkg::t_res_flags            o_flags,
    output logic [CW-1:0]                   o_flen,
    output logic [CW-1:0]                   o_fill,
    output logic [31:0]                     o_found,
    output logic [31:0]                     o_sent
);
    import hfpe_pkg::*;

    localparam logic [AW:0] DEPTH_A = (AW+1)'(BUF_DEPTH);
    localparam logic [CW:0] MIN_C   = (CW+1)'(MIN_LEN);

    function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
        logic [AW:0] t;
        t = (s >= DEPTH_A) ? (s - DEPTH_A) : s;
        return t[AW-1:0];
    endfunction

    t_state         r_state, n_state;
    logic [AW-1:0]  r_base, n_base;
    logic [CW-1:0]  r_fill, n_fill;
    logic [CW-1:0]  r_start, n_start;
    logic [CW-1:0]  r_len, n_len;
    logic [CW-1:0]  r_off, n_off;
    logic           r_ready, n_ready;
    logic [31:0]    r_found, n_found;
    logic [31:0]    r_sent, n_sent;
    logic [CW-1:0]  r_i, n_i;
    logic [7:0]     r_hi, n_hi;
    logic [CW-1:0]  r_total, n_total;
    t_res_flags     r_flags, n_flags;
    logic [CW-1:0]  r_flen, n_flen;

    logic           deliver;
    logic [CW-1:0]  dv_start, dv_off, dv_len;
    logic [CW:0]    dv_drop;
    logic [15:0]    dlen;
    logic [CW:0]    cand_total;
    logic [CW:0]    i_plus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_base  <= '0;
            r_fill  <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_off   <= '0;
            r_ready <= 1'b0;
            r_found <= '0;
            r_sent  <= '0;
            r_flags <= '0;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_fill  <= n_fill;
            r_start <= n_start;
            r_len   <= n_len;
            r_off   <= n_off;
            r_ready <= n_ready;
            r_found <= n_found;
            r_sent  <= n_sent;
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_hi    <= n_hi;
        r_total <= n_total;
        r_flen  <= n_flen;
    end

    assign dlen       = {r_hi, i_rdata};
    assign cand_total = (CW+1)'(MIN_LEN) + (CW+1)'(dlen);
    assign dv_drop    = (CW+1)'(dv_start) + (CW+1)'(dv_len);

    always_comb begin
        n_state  = r_state;
        n_base   = r_base;
        n_fill   = r_fill;
        n_start  = r_start;
        n_len    = r_len;
        n_off    = r_off;
        n_ready  = r_ready;
        n_found  = r_found;
        n_sent   = r_sent;
        n_i      = r_i;
        n_hi     = r_hi;
        n_total  = r_total;
        n_flags  = '0;
        n_flen   = '0;
        o_we     = 1'b0;
        o_waddr  = wrap((AW+1)'(r_base) + (AW+1)'(r_fill));
        o_wdata  = i_data_byte;
        o_raddr  = wrap((AW+1)'(r_base) + (AW+1)'(r_i));
        deliver  = 1'b0;
        dv_start = r_start;
        dv_off   = r_off;
        dv_len   = r_len;
        i_plus   = (CW+1)'(r_i) + 1'b1;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_flags.strobe = 1'b1;
                    case (t_mode'(i_mode))
                        MODE_PUSH: begin
                            if ((CW+1)'(r_fill) < (CW+1)'(BUF_DEPTH)) begin
                                o_we             = 1'b1;
                                n_fill           = r_fill + 1'b1;
                                n_flags.accepted = 1'b1;
                            end
                        end
                        MODE_POP: begin
                            if (r_ready) begin
                                deliver = 1'b1;
                            end else begin
                                // The result goes out when the search ends.
                                n_flags.strobe = 1'b0;
                                n_i            = '0;
                                n_state        = ST_CHK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CHK: begin
                if ((CW+1)'(r_i) + MIN_C > (CW+1)'(r_fill)) begin
                    n_base         = wrap((AW+1)'(r_base) + (AW+1)'(r_i));
                    n_fill         = r_fill - r_i;
                    n_flags.strobe = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    o_raddr = wrap((AW+1)'(r_base) + (AW+1)'(r_i));
                    n_state = ST_B0;
                end
            end
            ST_B0: begin
                if (i_rdata != HEAD_MARK) begin
                    n_i     = i_plus[CW-1:0];
                    n_state = ST_CHK;
                end else begin
                    o_raddr = wrap((AW+1)'(r_base) + (AW+1)'(r_i) + (AW+1)'(1));
                    n_state = ST_B1;
                end
            end
            ST_B1: begin
                if (i_rdata != HEAD_MARK) begin
                    n_i     = i_plus[CW-1:0];
                    n_state = ST_CHK;
                end else begin
                    o_raddr = wrap((AW+1)'(r_base) + (AW+1)'(r_i) + (AW+1)'(9));
                    n_state = ST_L0;
                end
            end
            ST_L0: begin
                n_hi    = i_rdata;
                o_raddr = wrap((AW+1)'(r_base) + (AW+1)'(r_i) + (AW+1)'(10));
                n_state = ST_L1;
            end
            ST_L1: begin
                if (32'(dlen) > 32'(BUF_DEPTH - MIN_LEN)) begin
                    n_i     = i_plus[CW-1:0];
                    n_state = ST_CHK;
                end else if ((CW+1)'(r_i) + cand_total > (CW+1)'(r_fill)) begin
                    // Partial frame: keep it, drop what lies in front of it.
                    n_base         = wrap((AW+1)'(r_base) + (AW+1)'(r_i));
                    n_fill         = r_fill - r_i;
                    n_flags.strobe = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    n_total = cand_total[CW-1:0];
                    o_raddr = wrap((AW+1)'(r_base) + (AW+1)'(r_i)
                                   + (AW+1)'(cand_total) - (AW+1)'(2));
                    n_state = ST_T0;
                end
            end
            ST_T0: begin
                if (i_rdata != TAIL_MARK) begin
                    n_i     = i_plus[CW-1:0];
                    n_state = ST_CHK;
                end else begin
                    o_raddr = wrap((AW+1)'(r_base) + (AW+1)'(r_i)
                                   + (AW+1)'(r_total) - (AW+1)'(1));
                    n_state = ST_T1;
                end
            end
            ST_T1: begin
                if (i_rdata != TAIL_MARK) begin
                    n_i     = i_plus[CW-1:0];
                    n_state = ST_CHK;
                end else begin
                    n_found = r_found + 1'b1;
                    if (32'(r_total) <= 32'(i_max_len)) begin
                        deliver        = 1'b1;
                        dv_start       = r_i;
                        dv_off         = '0;
                        dv_len         = r_total;
                        n_flags.strobe = 1'b1;
                        n_state        = ST_IDLE;
                    end else begin
                        // Too long: skip the whole frame.
                        n_i     = r_i + r_total;
                        n_state = ST_CHK;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (deliver) begin
            o_raddr             = wrap((AW+1)'(r_base) + (AW+1)'(dv_start)
                                       + (AW+1)'(dv_off));
            n_flags.frame_valid = 1'b1;
            n_flen              = dv_len;
            if ((CW+1)'(dv_off) + 1'b1 >= (CW+1)'(dv_len)) begin
                n_flags.last = 1'b1;
                n_base       = wrap((AW+1)'(r_base) + (AW+1)'(dv_drop));
                n_fill       = r_fill - dv_drop[CW-1:0];
                n_ready      = 1'b0;
                n_start      = '0;
                n_len        = '0;
                n_off        = '0;
                n_sent       = r_sent + 1'b1;
            end else begin
                n_ready = 1'b1;
                n_start = dv_start;
                n_len   = dv_len;
                n_off   = dv_off + 1'b1;
            end
        end
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_flags = r_flags;
    assign o_flen  = r_flen;
    assign o_fill  = r_fill;
    assign o_found = r_found;
    assign o_sent  = r_sent;

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.strobe |-> (r_state == ST_IDLE))
        else $error("result strobe while searching");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW+1)'(r_fill) <= (CW+1)'(BUF_DEPTH))
        else $error("fill count beyond store depth");

    a_frame_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> ((CW+1)'(r_start) + (CW+1)'(r_len) <= (CW+1)'(r_fill)))
        else $error("pending frame extends past stored bytes");

    a_full_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode == MODE_PUSH
         && (CW+1)'(r_fill) == (CW+1)'(BUF_DEPTH))
        |=> (r_flags.strobe && !r_flags.accepted))
        else $error("push into full store was taken");

endmodule

// ===== tb/tb.sv =====
// Testbench for the hash-framed packet extractor: predicted results checked per item.
`timescale 1ns / 1ps

module tb;
    import hfpe_pkg::*;

    localparam int DEPTH = 4096;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int ITEM_TARGET = 1800;

    typedef struct {
        logic        accepted;
        logic        frame_valid;
        logic [7:0]  out_byte;
        logic        last;
        logic [12:0] frame_length;
        logic [12:0] buffered_bytes;
        logic [31:0] received_frames;
        logic [31:0] delivered_frames;
    } t_frame_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_mode;
    logic [7:0]  i_data_byte;
    logic        i_cfg_we;
    logic [12:0] i_cfg_wdata;
    logic        o_strobe;
    logic        o_accepted;
    logic        o_frame_valid;
    logic [7:0]  o_out_byte;
    logic        o_last;
    logic [12:0] o_frame_length;
    logic [12:0] o_buffered_bytes;
    logic [31:0] o_received_frames;
    logic [31:0] o_delivered_frames;

    hash_framed_packet_extractor u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_mode             (i_mode),
        .i_data_byte        (i_data_byte),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_strobe           (o_strobe),
        .o_accepted         (o_accepted),
        .o_frame_valid      (o_frame_valid),
        .o_out_byte         (o_out_byte),
        .o_last             (o_last),
        .o_frame_length     (o_frame_length),
        .o_buffered_bytes   (o_buffered_bytes),
        .o_received_frames  (o_received_frames),
        .o_delivered_frames (o_delivered_frames)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predicted deframer state.
    logic [7:0]  pred_store [DEPTH];
    int          pred_fill;
    int          pred_start;
    int          pred_len;
    int          pred_offset;
    bit          pred_ready;
    logic [31:0] pred_found;
    logic [31:0] pred_sent;
    int          pred_max_len;

    t_frame_result expected_results[$];
    bit failed;
    int idle_cycles;
    int sent_items;

    function automatic void discard_front(int n);
        if (n > pred_fill) n = pred_fill;
        for (int k = 0; k < pred_fill - n; k++) pred_store[k] = pred_store[k + n];
        pred_fill -= n;
    endfunction

    function automatic void search_head();
        int i;
        int dlen;
        int total;
        i = 0;
        if (pred_fill < MIN_LEN) return;
        while (i + MIN_LEN <= pred_fill) begin
            if (pred_store[i] == HEAD_MARK && pred_store[i + 1] == HEAD_MARK) begin
                dlen = {pred_store[i + 9], pred_store[i + 10]};
                if (dlen > DEPTH - MIN_LEN) begin
                    i++;
                    continue;
                end
                total = MIN_LEN + dlen;
                if (i + total > pred_fill) begin
                    discard_front(i);
                    return;
                end
                if (pred_store[i + total - 2] == TAIL_MARK &&
                    pred_store[i + total - 1] == TAIL_MARK) begin
                    pred_found++;
                    if (total <= pred_max_len) begin
                        pred_start  = i;
                        pred_len    = total;
                        pred_offset = 0;
                        pred_ready  = 1'b1;
                        return;
                    end
                    i += total;
                    continue;
                end
            end
            i++;
        end
        discard_front(i);
    endfunction

    function automatic t_frame_result predict_item(t_mode mode, logic [7:0] data);
        t_frame_result r;
        r = '{default: '0};
        if (mode == MODE_PUSH) begin
            if (pred_fill < DEPTH) begin
                pred_store[pred_fill] = data;
                pred_fill++;
                r.accepted = 1'b1;
            end
        end else if (mode == MODE_POP) begin
            if (!pred_ready) search_head();
            if (pred_ready) begin
                r.frame_valid  = 1'b1;
                r.out_byte     = pred_store[pred_start + pred_offset];
                r.frame_length = 13'(pred_len);
                if (pred_offset + 1 >= pred_len) begin
                    r.last = 1'b1;
                    discard_front(pred_start + pred_len);
                    pred_ready  = 1'b0;
                    pred_start  = 0;
                    pred_len    = 0;
                    pred_offset = 0;
                    pred_sent++;
                end else begin
                    pred_offset++;
                end
            end
        end
        r.buffered_bytes   = 13'(pred_fill);
        r.received_frames  = pred_found;
        r.delivered_frames = pred_sent;
        return r;
    endfunction

    // Drives one item and holds it until the block takes it.
    task automatic send_item(t_mode mode, logic [7:0] data);
        int gap;
        start       = 1'b1;
        i_mode      = mode;
        i_data_byte = data;
        do @(posedge i_clk); while (busy);
        expected_results.push_back(predict_item(mode, data));
        sent_items++;
        @(negedge i_clk);
        gap = $urandom_range(0, 99);
        if (gap >= 55) begin
            start = 1'b0;
            if (gap < 92) repeat ($urandom_range(1, 3)) @(negedge i_clk);
            else repeat ($urandom_range(5, 40)) @(negedge i_clk);
        end
    endtask

    task automatic push_byte(logic [7:0] b);
        send_item(MODE_PUSH, b);
    endtask

    task automatic pop_bytes(int n);
        for (int k = 0; k < n; k++) send_item(MODE_POP, 8'h00);
    endtask

    // Pushes a head, header with length, data and tail; bad_tail corrupts the tail.
    task automatic push_frame(int dlen, bit bad_tail);
        push_byte(HEAD_MARK);
        push_byte(HEAD_MARK);
        for (int k = 2; k < 9; k++) push_byte(8'($urandom_range(0, 255)));
        push_byte(dlen[15:8]);
        push_byte(dlen[7:0]);
        for (int k = 0; k < dlen; k++) push_byte(8'($urandom_range(0, 255)));
        push_byte(TAIL_MARK);
        push_byte(bad_tail ? 8'h25 : TAIL_MARK);
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_max_len(logic [12:0] value);
        wait_drained();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we     = 1'b0;
        pred_max_len = value;
    endtask

    // Pops until a pop neither delivers, finds a frame nor drops bytes; what is left
    // is too short to hold a frame or is the start of an unfinished one.
    task automatic flush_store();
        int prev_fill;
        do begin
            prev_fill = pred_fill;
            pop_bytes(1);
        end while (pred_ready || pred_fill != prev_fill);
    endtask

    always @(posedge i_clk) begin
        t_frame_result e;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                $error("result with no item outstanding");
                failed = 1'b1;
            end else begin
                e = expected_results.pop_front();
                if (o_accepted !== e.accepted) begin
                    $error("accepted exp %0d got %0d", e.accepted, o_accepted);
                    failed = 1'b1;
                end
                if (o_frame_valid !== e.frame_valid) begin
                    $error("frame_valid exp %0d got %0d", e.frame_valid, o_frame_valid);
                    failed = 1'b1;
                end
                if (o_out_byte !== e.out_byte) begin
                    $error("out_byte exp %0h got %0h", e.out_byte, o_out_byte);
                    failed = 1'b1;
                end
                if (o_last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_last);
                    failed = 1'b1;
                end
                if (o_frame_length !== e.frame_length) begin
                    $error("frame_length exp %0d got %0d", e.frame_length, o_frame_length);
                    failed = 1'b1;
                end
                if (o_buffered_bytes !== e.buffered_bytes) begin
                    $error("buffered_bytes exp %0d got %0d", e.buffered_bytes,
                           o_buffered_bytes);
                    failed = 1'b1;
                end
                if (o_received_frames !== e.received_frames) begin
                    $error("received_frames exp %0d got %0d", e.received_frames,
                           o_received_frames);
                    failed = 1'b1;
                end
                if (o_delivered_frames !== e.delivered_frames) begin
                    $error("delivered_frames exp %0d got %0d", e.delivered_frames,
                           o_delivered_frames);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: counts cycles with no item taken and no result seen.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_basic_frames();
        push_frame(0, 1'b0);
        send_item(MODE_STATUS, 8'hFF);
        send_item(MODE_SPARE, 8'h00);
        pop_bytes(13);
        pop_bytes(1);
    endtask

    task automatic test_junk_and_bad_tail();
        push_byte(8'h23);
        push_byte(8'h55);
        push_frame(1, 1'b1);
        push_frame(2, 1'b0);
        flush_store();
    endtask

    task automatic test_length_guard();
        // Header length beyond the store is ignored, so the following frame is found.
        push_byte(HEAD_MARK);
        push_byte(HEAD_MARK);
        for (int k = 2; k < 9; k++) push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(TAIL_MARK);
        push_byte(TAIL_MARK);
        push_frame(0, 1'b0);
        flush_store();
    endtask

    task automatic test_partial_frame();
        push_byte(8'h11);
        push_frame(4, 1'b0);
        push_byte(HEAD_MARK);
        push_byte(HEAD_MARK);
        for (int k = 2; k < 9; k++) push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h05);
        pop_bytes(17);
        pop_bytes(1);
        for (int k = 0; k < 5; k++) push_byte(8'hA5);
        push_byte(TAIL_MARK);
        push_byte(TAIL_MARK);
        flush_store();
    endtask

    task automatic test_max_len_limits();
        write_max_len(13'd13);
        push_frame(0, 1'b0);
        push_frame(1, 1'b0);
        push_frame(0, 1'b0);
        flush_store();
        write_max_len(13'd20);
        push_frame(8, 1'b0);
        push_frame(7, 1'b0);
        flush_store();
        write_max_len(13'd4096);
        push_frame(300, 1'b0);
        flush_store();
    endtask

    task automatic test_random_traffic();
        int pick;
        int rounds;
        rounds = 0;
        while (sent_items < ITEM_TARGET) begin
            if (rounds % 12 == 0) write_max_len(13'($urandom_range(13, 60)));
            rounds++;
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                push_frame($urandom_range(0, 20), $urandom_range(0, 9) == 0);
            end else if (pick < 65) begin
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
            end else if (pick < 70) begin
                send_item(t_mode'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end else begin
                pop_bytes($urandom_range(1, 30));
            end
            if (pred_fill > 1500) flush_store();
        end
        flush_store();
        write_max_len(13'd4096);
    endtask

    initial begin
        failed       = 1'b0;
        idle_cycles  = 0;
        sent_items   = 0;
        start        = 1'b0;
        i_mode       = MODE_STATUS;
        i_data_byte  = 8'h00;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = 13'd0;
        pred_fill    = 0;
        pred_start   = 0;
        pred_len     = 0;
        pred_offset  = 0;
        pred_ready   = 1'b0;
        pred_found   = '0;
        pred_sent    = '0;
        pred_max_len = 4096;
        i_rst_n      = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_basic_frames();
        test_junk_and_bad_tail();
        test_length_guard();
        test_partial_frame();
        test_max_len_limits();
        test_random_traffic();

        wait_drained();
        repeat (30) @(negedge i_clk);
        if (!failed && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
